// ===== rtl/core/prlm_pkg.sv =====
`default_nettype none
package prlm_pkg;
   localparam int METERS      = 16;
   localparam int MAX_BLOCK   = 8192;
   localparam int IDX_W       = 4;
   localparam int SAMPLE_W    = 24;
   localparam int LEVEL_W     = 24;
   localparam int SUM_W       = 60;
   localparam int COUNT_W     = 14;
   localparam int HOLD_W      = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [LEVEL_W-1:0] FULL_SCALE = 24'd65536;
   localparam logic [15:0] DECAY_MUL = 16'd58982;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd84;
   localparam logic [0:0] REG_CLIP_HOLD = 1'd0;

   // finished block handed from front to back
   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [LEVEL_W-1:0] peak;
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } block_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_SQRT, ST_READ, ST_WRITE, ST_SEND
   } back_state_type;

   // decay by about 0.9
   function automatic logic [LEVEL_W-1:0] decay(input logic [LEVEL_W-1:0] v);
      logic [LEVEL_W+15:0] p;
      p = v * DECAY_MUL;
      return p[LEVEL_W+15:16];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/prlm_stream_if.sv =====
`default_nettype none
interface prlm_stream_if #(parameter int WIDTH = 1);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/prlm_front.sv =====
`default_nettype none
module prlm_front import prlm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic [IDX_W-1:0]    meter_index,
   input  wire logic                last_in_block,
   output logic                     blk_valid,
   input  wire logic                blk_ready,
   output block_type                blk
);
   logic [LEVEL_W-1:0] peak_ff, peak_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LEVEL_W-1:0] mag;
   logic [2*LEVEL_W-1:0] sq;
   logic accept;

   assign in_ready  = blk_ready;
   assign accept    = in_valid && in_ready;
   assign mag       = sample[SAMPLE_W-1] ? LEVEL_W'(-sample) : LEVEL_W'(sample);
   assign sq        = mag * mag;

   // accumulate peak and square sum
   always_comb begin
      peak_in  = (mag > peak_ff) ? mag : peak_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (32'(count_ff) < MAX_BLOCK) begin
         sum_in   = sum_ff + SUM_W'(sq);
         count_in = count_ff + 1'b1;
      end
   end

   assign blk_valid = accept && last_in_block && (32'(meter_index) < METERS);
   assign blk.idx   = meter_index;
   assign blk.peak  = peak_in;
   assign blk.sum   = sum_in;
   assign blk.count = count_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && last_in_block)) begin
         peak_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         peak_ff  <= peak_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   ap_count: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_BLOCK) else $error("count overflow");
   ap_clear: assert property (@(posedge clock) disable iff (reset)
      accept && last_in_block |=> count_ff == '0) else $error("no clear");
   ap_peak: assert property (@(posedge clock) disable iff (reset)
      accept && !last_in_block |=> peak_ff >= $past(peak_ff)) else $error("peak drop");
endmodule
`default_nettype wire

// ===== rtl/core/prlm_queue.sv =====
`default_nettype none
module prlm_queue import prlm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_valid,
   output logic      wr_ready,
   input  block_type wr_data,
   output logic      rd_valid,
   input  wire logic rd_ready,
   output block_type rd_data
);
   block_type slot_ff [QUEUE_DEPTH];
   logic [$clog2(QUEUE_DEPTH)-1:0] wp_ff, rp_ff;
   logic [$clog2(QUEUE_DEPTH):0] fill_ff;
   logic push, pop;

   assign wr_ready = 32'(fill_ff) < QUEUE_DEPTH;
   assign rd_valid = fill_ff != '0;
   assign rd_data  = slot_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= wr_data;
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; fill_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         fill_ff <= fill_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      end
   end

   ap_fill: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= QUEUE_DEPTH) else $error("queue overfill");
   ap_flow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> fill_ff == $past(fill_ff) + 1'b1) else $error("fill lost");
   ap_empty: assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 |-> !pop) else $error("pop empty");
endmodule
`default_nettype wire

// ===== rtl/core/prlm_back.sv =====
`default_nettype none
module prlm_back import prlm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [HOLD_W-1:0] clip_hold_len,
   input  wire logic              blk_valid,
   output logic                   blk_ready,
   input  block_type              blk,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [IDX_W-1:0]       meter_id,
   output logic [LEVEL_W-1:0]     meter_peak,
   output logic [LEVEL_W-1:0]     meter_rms,
   output logic                   clipped
);
   back_state_type state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [LEVEL_W-1:0] peak_ff;
   logic [SUM_W-1:0]   rem_ff, quo_ff;
   logic [COUNT_W-1:0] div_ff;
   logic [5:0]         step_ff;
   logic [SUM_W-1:0]   root_ff, bit_ff;
   logic [LEVEL_W-1:0] rms_ff, spk_ff, srms_ff, opeak_ff, orms_ff;
   logic [HOLD_W-1:0]  shold_ff, ohold_ff;
   logic [METERS-1:0]  vld_ff;
   logic [LEVEL_W-1:0] pk_mem [METERS];
   logic [LEVEL_W-1:0] rm_mem [METERS];
   logic [HOLD_W-1:0]  hd_mem [METERS];
   logic [SUM_W-1:0]   rb;
   logic [LEVEL_W-1:0] npeak, nrms;
   logic [HOLD_W-1:0]  nhold;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (blk_valid) state_in = ST_DIV;
         ST_DIV:   if (step_ff == 6'd0) state_in = ST_SQRT;
         ST_SQRT:  if (bit_ff == '0) state_in = ST_READ;
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: state_in = ST_SEND;
         ST_SEND:  if (out_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      blk_ready = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: blk_ready = 1'b1;
         ST_SEND: out_valid = 1'b1;
         default: ;
      endcase
   end

   assign rb    = root_ff + bit_ff;
   assign npeak = (peak_ff > spk_ff) ? peak_ff : decay(spk_ff);
   assign nrms  = (rms_ff > srms_ff) ? rms_ff : decay(srms_ff);
   assign nhold = (peak_ff > FULL_SCALE) ? clip_hold_len :
                  (shold_ff != '0) ? shold_ff - 1'b1 : shold_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // restoring divide, one quotient bit per cycle, then digit square root
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            idx_ff  <= blk.idx;
            peak_ff <= blk.peak;
            rem_ff  <= '0;
            quo_ff  <= blk.sum;
            div_ff  <= blk.count;
            step_ff <= 6'(SUM_W);
         end
         ST_DIV: begin
            if (step_ff != 6'd0) begin
               if ({rem_ff[SUM_W-2:0], quo_ff[SUM_W-1]} >= SUM_W'(div_ff)) begin
                  rem_ff <= {rem_ff[SUM_W-2:0], quo_ff[SUM_W-1]} - SUM_W'(div_ff);
                  quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[SUM_W-2:0], quo_ff[SUM_W-1]};
                  quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
               end
               step_ff <= step_ff - 1'b1;
            end else begin
               root_ff <= '0;
               bit_ff  <= SUM_W'(1) << (SUM_W - 2);
            end
         end
         ST_SQRT: begin
            if (bit_ff != '0) begin
               if (quo_ff >= rb) begin
                  quo_ff  <= quo_ff - rb;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
            rms_ff <= LEVEL_W'(root_ff);
         end
         ST_READ: begin
            spk_ff   <= vld_ff[idx_ff] ? pk_mem[idx_ff] : '0;
            srms_ff  <= vld_ff[idx_ff] ? rm_mem[idx_ff] : '0;
            shold_ff <= vld_ff[idx_ff] ? hd_mem[idx_ff] : '0;
         end
         ST_WRITE: begin
            pk_mem[idx_ff] <= npeak;
            rm_mem[idx_ff] <= nrms;
            hd_mem[idx_ff] <= nhold;
            opeak_ff <= npeak;
            orms_ff  <= nrms;
            ohold_ff <= nhold;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (state_ff == ST_WRITE) vld_ff[idx_ff] <= 1'b1;
   end

   assign meter_id   = idx_ff;
   assign meter_peak = opeak_ff;
   assign meter_rms  = orms_ff;
   assign clipped    = ohold_ff != '0;

   ap_send: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(opeak_ff)) else $error("send lost");
   ap_take: assert property (@(posedge clock) disable iff (reset)
      blk_ready |-> state_ff == ST_IDLE) else $error("take busy");
   ap_wr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |=> vld_ff[$past(idx_ff)]) else $error("valid lost");
endmodule
`default_nettype wire

// ===== rtl/core/peak_rms_level_meter_unit.sv =====
`default_nettype none
// Peak/RMS level meter. Samples enter at one per cycle while the queue has
// room and accumulate in the front; each block end pushes a record into a
// two-entry queue. The back unit takes the record, runs the restoring divide
// and the square root, reads and writes the meter, and holds its output until
// it is taken before taking the next record, so the input stalls whenever the
// queue is full. The clip hold register (address 0) is written over the
// APB-style port.
module peak_rms_level_meter_unit import prlm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   prlm_stream_if.sink       req,
   prlm_stream_if.source     rsp,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [0:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic [HOLD_W-1:0] hold_ff;
   logic f_valid, f_ready, b_valid, b_ready;
   block_type f_blk, b_blk;
   logic [IDX_W-1:0] o_id;
   logic [LEVEL_W-1:0] o_pk, o_rm;
   logic o_cl;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_CLIP_HOLD) ? 32'(hold_ff) : '0;

   // hold register write
   always_ff @(posedge clock) begin
      if (reset) hold_ff <= HOLD_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_CLIP_HOLD)
         hold_ff <= csr_pwdata[HOLD_W-1:0];
   end

   prlm_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .sample(req.data[SAMPLE_W-1:0]),
      .meter_index(req.data[SAMPLE_W+IDX_W-1:SAMPLE_W]),
      .last_in_block(req.data[SAMPLE_W+IDX_W]),
      .blk_valid(f_valid), .blk_ready(f_ready), .blk(f_blk)
   );

   prlm_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_blk),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_blk)
   );

   prlm_back u_back (
      .clock, .reset, .clip_hold_len(hold_ff),
      .blk_valid(b_valid), .blk_ready(b_ready), .blk(b_blk),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .meter_id(o_id), .meter_peak(o_pk), .meter_rms(o_rm), .clipped(o_cl)
   );

   assign rsp.data = {o_cl, o_rm, o_pk, o_id};
endmodule
`default_nettype wire

// ===== verif/tb_peak_rms_level_meter_unit.sv =====
`default_nettype none
module tb_peak_rms_level_meter_unit;
   import prlm_pkg::*;

   typedef struct packed {
      logic                       last;
      logic [IDX_W-1:0]           idx;
      logic signed [SAMPLE_W-1:0] sample;
   } sample_word_t;

   typedef struct packed {
      logic               clipped;
      logic [LEVEL_W-1:0] rms;
      logic [LEVEL_W-1:0] peak;
      logic [IDX_W-1:0]   meter_id;
   } level_word_t;

   typedef struct {
      int         sample;
      int         idx;
      bit         last;
      bit         known;
      int         peak;
      int         rms;
      bit         clipped;
   } table_row_t;

   logic clock;
   logic reset;

   prlm_stream_if #(.WIDTH($bits(sample_word_t))) req_if ();
   prlm_stream_if #(.WIDTH($bits(level_word_t)))  rsp_if ();

   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [0:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   peak_rms_level_meter_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if.sink),
      .rsp         (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // level predictor state
   logic [HOLD_W-1:0]  hold_setting;
   logic [LEVEL_W-1:0] blk_peak;
   logic [63:0]        blk_sum;
   int unsigned        blk_count;
   logic [LEVEL_W-1:0] peak_mem [METERS];
   logic [LEVEL_W-1:0] rms_mem  [METERS];
   logic [HOLD_W-1:0]  clip_mem [METERS];

   level_word_t expected_levels[$];
   int          error_count;
   int          items_sent;
   int          burst_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [31:0] root_of(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitpos;
      res = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (v >= res + bitpos) begin
            v = v - (res + bitpos);
            res = (res >> 1) + bitpos;
         end else begin
            res = res >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return res[31:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] hold_or_fade(input logic [LEVEL_W-1:0] stored,
                                                       input logic [LEVEL_W-1:0] fresh);
      logic [63:0] p;
      if (fresh > stored) return fresh;
      p = 64'(stored) * 64'd58982;
      return p[LEVEL_W+15:16];
   endfunction

   task automatic clear_levels();
      blk_peak = 0;
      blk_sum = 0;
      blk_count = 0;
      for (int i = 0; i < METERS; i++) begin
         peak_mem[i] = 0;
         rms_mem[i] = 0;
         clip_mem[i] = 0;
      end
   endtask

   // fold one accepted word into the meters, return the level it causes
   function automatic bit predict_level(input sample_word_t w, output level_word_t lv);
      logic [LEVEL_W-1:0] mag;
      logic [LEVEL_W-1:0] pk;
      logic [LEVEL_W-1:0] rm;
      mag = w.sample[SAMPLE_W-1] ? LEVEL_W'(-$signed({1'b1, w.sample})) : w.sample;
      if (mag > blk_peak) blk_peak = mag;
      if (blk_count < MAX_BLOCK) begin
         blk_sum += 64'(mag) * 64'(mag);
         blk_count++;
      end
      if (!w.last) return 1'b0;
      pk = blk_peak;
      rm = LEVEL_W'(root_of(blk_sum / blk_count));
      blk_peak = 0;
      blk_sum = 0;
      blk_count = 0;
      peak_mem[w.idx] = hold_or_fade(peak_mem[w.idx], pk);
      rms_mem[w.idx] = hold_or_fade(rms_mem[w.idx], rm);
      if (pk > FULL_SCALE) clip_mem[w.idx] = hold_setting;
      else if (clip_mem[w.idx] > 0) clip_mem[w.idx]--;
      lv.meter_id = w.idx;
      lv.peak = peak_mem[w.idx];
      lv.rms = rms_mem[w.idx];
      lv.clipped = clip_mem[w.idx] != 0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // send one word, then advance the predictor once it is accepted
   task automatic send_word(input sample_word_t w, output level_word_t lv, output bit made);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 :
               ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 5);
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(100, 400) : $urandom_range(1, 30);
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data <= w;
      do @(posedge clock); while (!req_if.ready);
      made = predict_level(w, lv);
      if (made) expected_levels.push_back(lv);
      items_sent++;
   endtask

   task automatic write_hold(input logic [HOLD_W-1:0] value);
      @(negedge clock);
      req_if.valid <= 1'b0;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_CLIP_HOLD;
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      hold_setting = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // drop valid, then hold until every level has come back and the back end is quiet
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic sample_word_t random_sample(input bit last);
      sample_word_t w;
      case ($urandom_range(0, 9)) inside
         [0:2]:   w.sample = SAMPLE_W'($urandom);
         3:       w.sample = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         [4:5]:   w.sample = SAMPLE_W'($signed(24'($urandom_range(60000, 70000))) *
                                       ($urandom_range(0, 1) ? 1 : -1));
         default: w.sample = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      endcase
      w.idx = IDX_W'($urandom_range(0, METERS - 1));
      w.last = last;
      return w;
   endfunction

   task automatic send_blocks(input int n_items);
      sample_word_t w;
      level_word_t  lv;
      bit           made;
      int           len;
      int           target;
      target = items_sent + n_items;
      while (items_sent < target) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120) : $urandom_range(1, 12);
         for (int k = 0; k < len; k++) begin
            w = random_sample(k == len - 1);
            send_word(w, lv, made);
         end
      end
   endtask

   // receiver stall pattern
   int ready_mode;
   int ready_left;
   int stall_left;
   initial begin
      rsp_if.ready = 1'b0;
      ready_mode = 0;
      ready_left = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(50, 600);
         end
         ready_left--;
         case (ready_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= $urandom_range(0, 1);
            2: rsp_if.ready <= $urandom_range(0, 7) != 0;
            default: begin
               if (stall_left == 0) stall_left = $urandom_range(1, 150);
               stall_left--;
               rsp_if.ready <= stall_left < 3;
            end
         endcase
      end
   end

   // compare each level word with the oldest prediction
   always @(posedge clock) begin
      level_word_t got;
      level_word_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (expected_levels.size() == 0) begin
            report_mismatch("unexpected level word, meter", got.meter_id, -1);
         end else begin
            want = expected_levels.pop_front();
            if (got.meter_id != want.meter_id)
               report_mismatch("meter_id", got.meter_id, want.meter_id);
            if (got.peak != want.peak) report_mismatch("meter_peak", got.peak, want.peak);
            if (got.rms != want.rms) report_mismatch("meter_rms", got.rms, want.rms);
            if (got.clipped != want.clipped)
               report_mismatch("clipped", got.clipped, want.clipped);
         end
      end
   end

   table_row_t directed_rows [17] = '{
      '{0,        0, 1, 1, 0,       0,       0},
      '{-8388608, 1, 1, 1, 8388608, 8388608, 1},
      '{8388607,  2, 1, 1, 8388607, 8388607, 1},
      '{65536,    3, 1, 1, 65536,   65536,   0},
      '{65537,    3, 1, 1, 65537,   65537,   1},
      '{0,        3, 1, 1, 58982,   58982,   1},
      '{0,        1, 1, 1, 7549696, 7549696, 1},
      '{3,        9, 0, 0, 0, 0, 0},
      '{-4,       2, 0, 0, 0, 0, 0},
      '{5,        4, 1, 0, 0, 0, 0},
      '{-1,       5, 1, 0, 0, 0, 0},
      '{1000000,  7, 0, 0, 0, 0, 0},
      '{-1000000, 7, 0, 0, 0, 0, 0},
      '{12345,   15, 1, 0, 0, 0, 0},
      '{-65537,  14, 0, 0, 0, 0, 0},
      '{65535,   14, 1, 0, 0, 0, 0},
      '{1,       15, 1, 0, 0, 0, 0}
   };

   initial begin
      sample_word_t w;
      level_word_t  lv;
      bit           made;
      error_count = 0;
      items_sent = 0;
      burst_left = 0;
      hold_setting = HOLD_RESET;
      clear_levels();
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at the reset hold setting
      foreach (directed_rows[i]) begin
         w.sample = SAMPLE_W'(directed_rows[i].sample);
         w.idx = IDX_W'(directed_rows[i].idx);
         w.last = directed_rows[i].last;
         send_word(w, lv, made);
         if (directed_rows[i].known) begin
            if (lv.peak != directed_rows[i].peak)
               report_mismatch("table peak", lv.peak, directed_rows[i].peak);
            if (lv.rms != directed_rows[i].rms)
               report_mismatch("table rms", lv.rms, directed_rows[i].rms);
            if (lv.clipped != directed_rows[i].clipped)
               report_mismatch("table clipped", lv.clipped, directed_rows[i].clipped);
         end
      end
      send_blocks(300);

      drain();
      write_hold(16'd1);
      send_blocks(350);
      drain();
      write_hold(16'd0);
      send_blocks(300);
      drain();
      write_hold(16'hFFFF);
      send_blocks(350);
      drain();
      write_hold(HOLD_W'($urandom_range(2, 20)));
      send_blocks(550);

      drain();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
